[rtl/kpia_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpia_pkg: shared types and constants of the keyboard interface adapter
// Transaction payloads, bus window, register offsets, control flag bits and
// the internal control and status groups.
// ----------------------------------------------------------------------------
package kpia_pkg;

    // key fifo geometry
    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // bus window
    localparam int BASE_ADDRESS = 53264;
    localparam int WINDOW_SPAN  = 8;
    localparam int ADDR_W       = 16;
    localparam int OFS_W        = $clog2(WINDOW_SPAN);
    localparam logic [ADDR_W:0] WIN_LO = (ADDR_W + 1)'(BASE_ADDRESS);
    localparam logic [ADDR_W:0] WIN_HI = (ADDR_W + 1)'(BASE_ADDRESS + WINDOW_SPAN);

    // transaction codes
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_KEY   = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // register offsets within the window
    localparam logic [OFS_W-1:0] OFS_A_DATA = OFS_W'(0);
    localparam logic [OFS_W-1:0] OFS_A_DIR  = OFS_W'(1);
    localparam logic [OFS_W-1:0] OFS_A_CTRL = OFS_W'(2);
    localparam logic [OFS_W-1:0] OFS_B_DATA = OFS_W'(3);
    localparam logic [OFS_W-1:0] OFS_B_DIR  = OFS_W'(4);
    localparam logic [OFS_W-1:0] OFS_B_CTRL = OFS_W'(5);

    // port A control flag bits
    localparam int FLAG_AVAIL = 7;
    localparam int FLAG_FULL  = 6;
    localparam int FLAG_IRQ   = 5;
    localparam int FLAG_IEN   = 0;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  key_code;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       key_accepted;
        logic       irq;
        logic [4:0] queued_keys;
    } t_out_item;

    // fifo control and status
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] key;
    } t_fifo_ctl;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             empty;
        logic             full;
    } t_fifo_sts;

    // register bank write request
    typedef struct packed {
        logic             en;
        logic [OFS_W-1:0] ofs;
        logic [7:0]       data;
    } t_reg_wr;

endpackage

[rtl/keyboard_pia_with_fifo_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_pia_with_fifo_core: two-port interface adapter with key fifo
// Bus writes, bus reads and keypresses in; one result per transaction out.
// ----------------------------------------------------------------------------
// Each transaction is one bus write, one bus read or one keypress and yields
// exactly one result. A transaction is captured in an input register, decoded
// and executed against the fifo and register bank once the output register is
// free or draining, and its result lands in that output register. A new
// transaction can be taken every cycle unless a result waits on i_out_stall.
// While a result waits, the input register still holds one more transaction.
// Reads of port A data pop the oldest key (zero when empty); reads of the
// port A control register show live available, full and interrupt flags.
// ----------------------------------------------------------------------------
module keyboard_pia_with_fifo_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  kpia_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output kpia_pkg::t_out_item o_out_item
);

    // input register
    logic               r_in_valid;
    kpia_pkg::t_in_item r_in;

    // output register
    logic                r_out_valid;
    kpia_pkg::t_out_item r_out;
    kpia_pkg::t_out_item n_out_item;

    // execute-stage signals
    logic                       w_fire;
    logic                       w_in_window;
    logic [kpia_pkg::ADDR_W-1:0] w_addr_diff;
    logic [kpia_pkg::OFS_W-1:0] w_ofs;
    logic                       w_is_write;
    logic                       w_is_read;
    logic                       w_is_key;
    logic                       w_read_a_data;

    kpia_pkg::t_fifo_ctl        w_fifo_ctl;
    kpia_pkg::t_fifo_sts        w_fifo_sts;
    logic [7:0]                 w_fifo_head;
    logic [kpia_pkg::CNT_W-1:0] w_next_count;

    kpia_pkg::t_reg_wr          w_reg_wr;
    logic [7:0]                 w_reg_rd_data;
    logic                       w_next_ien;

    // the held transaction executes when the result register is free or draining
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    // address window decode
    assign w_in_window = ({1'b0, r_in.address} >= kpia_pkg::WIN_LO)
                      && ({1'b0, r_in.address} <  kpia_pkg::WIN_HI);
    assign w_addr_diff = r_in.address - kpia_pkg::ADDR_W'(kpia_pkg::BASE_ADDRESS);
    assign w_ofs       = w_addr_diff[kpia_pkg::OFS_W-1:0];

    assign w_is_write = (kpia_pkg::t_op'(r_in.operation) == kpia_pkg::OP_WRITE);
    assign w_is_read  = (kpia_pkg::t_op'(r_in.operation) == kpia_pkg::OP_READ);
    assign w_is_key   = (kpia_pkg::t_op'(r_in.operation) == kpia_pkg::OP_KEY);

    assign w_read_a_data = w_is_read && w_in_window && (w_ofs == kpia_pkg::OFS_A_DATA);

    // fifo: push a key unless full, pop on a port A data read unless empty
    assign w_fifo_ctl.push = w_fire && w_is_key && !w_fifo_sts.full;
    assign w_fifo_ctl.pop  = w_fire && w_read_a_data && !w_fifo_sts.empty;
    assign w_fifo_ctl.key  = r_in.key_code;

    kpia_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_fifo_ctl),
        .o_sts        (w_fifo_sts),
        .o_head       (w_fifo_head),
        .o_next_count (w_next_count)
    );

    // register bank: writes outside the window are dropped
    assign w_reg_wr.en   = w_fire && w_is_write && w_in_window;
    assign w_reg_wr.ofs  = w_ofs;
    assign w_reg_wr.data = r_in.write_data;

    kpia_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_reg_wr),
        .i_rd_ofs   (w_ofs),
        .i_fifo_sts (w_fifo_sts),
        .o_rd_data  (w_reg_rd_data),
        .o_next_ien (w_next_ien)
    );

    // result assembly
    always_comb begin
        n_out_item = '0;
        if (w_read_a_data) begin
            n_out_item.read_data = w_fifo_sts.empty ? 8'h00 : w_fifo_head;
        end else if (w_is_read && w_in_window) begin
            n_out_item.read_data = w_reg_rd_data;
        end
        n_out_item.key_accepted = w_is_key && !w_fifo_sts.full;
        // interrupt flag as it stands after this transaction
        n_out_item.irq          = (w_next_count != '0) && w_next_ien;
        n_out_item.queued_keys  = 5'(w_next_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[rtl/kpia_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpia_fifo: keyboard key fifo
// Circular key store with write and read slots and a fill count.
// ----------------------------------------------------------------------------
module kpia_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kpia_pkg::t_fifo_ctl       i_ctl,
    output kpia_pkg::t_fifo_sts       o_sts,
    output logic [7:0]                o_head,
    output logic [kpia_pkg::CNT_W-1:0] o_next_count
);

    logic [7:0]                 r_store [kpia_pkg::FIFO_DEPTH];
    logic [7:0]                 r_head;
    logic [kpia_pkg::PTR_W-1:0] r_wr_slot;
    logic [kpia_pkg::PTR_W-1:0] r_rd_slot;
    logic [kpia_pkg::CNT_W-1:0] r_count;
    logic [kpia_pkg::PTR_W-1:0] n_wr_slot;
    logic [kpia_pkg::PTR_W-1:0] n_rd_slot;
    logic [kpia_pkg::CNT_W-1:0] n_count;

    localparam logic [kpia_pkg::PTR_W-1:0] LAST_SLOT =
        kpia_pkg::PTR_W'(kpia_pkg::FIFO_DEPTH - 1);

    always_comb begin
        n_wr_slot = r_wr_slot;
        n_rd_slot = r_rd_slot;
        n_count   = r_count;
        if (i_ctl.push) begin
            n_wr_slot = (r_wr_slot == LAST_SLOT) ? '0 : r_wr_slot + 1'b1;
            n_count   = r_count + 1'b1;
        end else if (i_ctl.pop) begin
            n_rd_slot = (r_rd_slot == LAST_SLOT) ? '0 : r_rd_slot + 1'b1;
            n_count   = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_slot <= '0;
            r_rd_slot <= '0;
            r_count   <= '0;
        end else begin
            r_wr_slot <= n_wr_slot;
            r_rd_slot <= n_rd_slot;
            r_count   <= n_count;
        end
    end

    // store contents need no reset, an entry is read only after a push
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_store[r_wr_slot] <= i_ctl.key;
        end
        // oldest key, taken straight from the push when it lands on the read slot
        if (i_ctl.push && (r_wr_slot == r_rd_slot)) begin
            r_head <= i_ctl.key;
        end else begin
            r_head <= r_store[n_rd_slot];
        end
    end

    assign o_head       = r_head;
    assign o_next_count = n_count;
    assign o_sts.count  = r_count;
    assign o_sts.empty  = (r_count == '0);
    assign o_sts.full   = (r_count == kpia_pkg::CNT_W'(kpia_pkg::FIFO_DEPTH));

endmodule

[rtl/kpia_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpia_regs: direction, control and port B output registers
// Register writes, read mux and port A control flag mirroring.
// ----------------------------------------------------------------------------
module kpia_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  kpia_pkg::t_reg_wr          i_wr,
    input  logic [kpia_pkg::OFS_W-1:0] i_rd_ofs,
    input  kpia_pkg::t_fifo_sts        i_fifo_sts,
    output logic [7:0]                 o_rd_data,
    output logic                       o_next_ien
);

    logic [7:0] r_dir_a, r_ctrl_a, r_out_b, r_dir_b, r_ctrl_b;
    logic [7:0] n_dir_a, n_ctrl_a, n_out_b, n_dir_b, n_ctrl_b;
    logic [7:0] w_ctrl_a_view;

    always_comb begin
        n_dir_a  = r_dir_a;
        n_ctrl_a = r_ctrl_a;
        n_out_b  = r_out_b;
        n_dir_b  = r_dir_b;
        n_ctrl_b = r_ctrl_b;
        if (i_wr.en) begin
            unique case (i_wr.ofs)
                kpia_pkg::OFS_A_DIR:  n_dir_a  = i_wr.data;
                kpia_pkg::OFS_A_CTRL: n_ctrl_a = i_wr.data;
                kpia_pkg::OFS_B_DATA: n_out_b  = i_wr.data;
                kpia_pkg::OFS_B_DIR:  n_dir_b  = i_wr.data;
                kpia_pkg::OFS_B_CTRL: n_ctrl_b = i_wr.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_a  <= '0;
            r_ctrl_a <= '0;
            r_out_b  <= '0;
            r_dir_b  <= '0;
            r_ctrl_b <= '0;
        end else begin
            r_dir_a  <= n_dir_a;
            r_ctrl_a <= n_ctrl_a;
            r_out_b  <= n_out_b;
            r_dir_b  <= n_dir_b;
            r_ctrl_b <= n_ctrl_b;
        end
    end

    // status flags always follow the fifo
    always_comb begin
        w_ctrl_a_view                       = r_ctrl_a;
        w_ctrl_a_view[kpia_pkg::FLAG_AVAIL] = !i_fifo_sts.empty;
        w_ctrl_a_view[kpia_pkg::FLAG_FULL]  = i_fifo_sts.full;
        w_ctrl_a_view[kpia_pkg::FLAG_IRQ]   = !i_fifo_sts.empty
                                              && r_ctrl_a[kpia_pkg::FLAG_IEN];
    end

    always_comb begin
        unique case (i_rd_ofs)
            kpia_pkg::OFS_A_DIR:  o_rd_data = r_dir_a;
            kpia_pkg::OFS_A_CTRL: o_rd_data = w_ctrl_a_view;
            kpia_pkg::OFS_B_DATA: o_rd_data = r_out_b;
            kpia_pkg::OFS_B_DIR:  o_rd_data = r_dir_b;
            kpia_pkg::OFS_B_CTRL: o_rd_data = r_ctrl_b;
            default:              o_rd_data = '0;
        endcase
    end

    assign o_next_ien = n_ctrl_a[kpia_pkg::FLAG_IEN];

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for keyboard_pia_with_fifo_core
// Drives bus writes, bus reads and keypresses through the input channel with
// random gaps, and stalls the result channel at random. A behavioral model of
// the adapter, updated as each transaction is accepted, predicts the result of
// every transaction. The monitor compares each result field by field against
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    // pending stimulus entry: hold marks a transaction that waits until
    // every earlier result has come back
    typedef struct packed {
        logic               hold;
        kpia_pkg::t_in_item item;
    } t_stim;

    localparam int USEFUL_ITEMS = 1100;
    localparam int IDLE_LIMIT   = 4000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                o_in_stall;
    kpia_pkg::t_in_item  in_item = '0;
    logic                o_out_valid;
    logic                out_stall = 1'b0;
    kpia_pkg::t_out_item o_out_item;

    // stimulus and expected results
    t_stim               pending_items[$];
    kpia_pkg::t_out_item expected_results[$];
    bit                  hold_next = 1'b0;
    int                  useful_count = 0;

    // model of the adapter state
    logic [7:0]                 key_fifo [kpia_pkg::FIFO_DEPTH];
    logic [kpia_pkg::PTR_W-1:0] push_slot;
    logic [kpia_pkg::PTR_W-1:0] pop_slot;
    int                         keys_held;
    logic [7:0]                 dir_a, ctrl_a, out_b, dir_b, ctrl_b;

    // bookkeeping
    int fail_count = 0;
    int gap_left = 0;
    int stall_left = 0;
    int sent_count = 0;
    int cycle_count = 0;
    int idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    keyboard_pia_with_fifo_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    // ------------------------------------------------------------------------
    // adapter model
    // ------------------------------------------------------------------------
    function automatic void clear_adapter();
        push_slot = '0;
        pop_slot  = '0;
        keys_held = 0;
        dir_a     = '0;
        ctrl_a    = '0;
        out_b     = '0;
        dir_b     = '0;
        ctrl_b    = '0;
    endfunction

    // port A control always mirrors the fifo status
    function automatic void mirror_flags();
        ctrl_a[kpia_pkg::FLAG_AVAIL] = (keys_held > 0);
        ctrl_a[kpia_pkg::FLAG_FULL]  = (keys_held >= kpia_pkg::FIFO_DEPTH);
        ctrl_a[kpia_pkg::FLAG_IRQ]   = (keys_held > 0) && ctrl_a[kpia_pkg::FLAG_IEN];
    endfunction

    function automatic kpia_pkg::t_out_item adapter_result(kpia_pkg::t_in_item it);
        kpia_pkg::t_out_item        res;
        logic [kpia_pkg::OFS_W-1:0] ofs;
        bit                         hit;
        int                         addr;
        res  = '0;
        addr = int'(it.address);
        hit  = (addr >= kpia_pkg::BASE_ADDRESS)
            && (addr < kpia_pkg::BASE_ADDRESS + kpia_pkg::WINDOW_SPAN);
        ofs  = kpia_pkg::OFS_W'(addr - kpia_pkg::BASE_ADDRESS);
        case (kpia_pkg::t_op'(it.operation))
            kpia_pkg::OP_WRITE: if (hit) begin
                // port A data and reserved offsets drop the write
                case (ofs)
                    kpia_pkg::OFS_A_DIR:  dir_a  = it.write_data;
                    kpia_pkg::OFS_A_CTRL: ctrl_a = it.write_data;
                    kpia_pkg::OFS_B_DATA: out_b  = it.write_data;
                    kpia_pkg::OFS_B_DIR:  dir_b  = it.write_data;
                    kpia_pkg::OFS_B_CTRL: ctrl_b = it.write_data;
                    default: ;
                endcase
            end
            kpia_pkg::OP_READ: if (hit) begin
                case (ofs)
                    kpia_pkg::OFS_A_DATA: if (keys_held > 0) begin
                        res.read_data = key_fifo[pop_slot];
                        pop_slot++;
                        keys_held--;
                    end
                    kpia_pkg::OFS_A_DIR:  res.read_data = dir_a;
                    kpia_pkg::OFS_A_CTRL: res.read_data = ctrl_a;
                    kpia_pkg::OFS_B_DATA: res.read_data = out_b;
                    kpia_pkg::OFS_B_DIR:  res.read_data = dir_b;
                    kpia_pkg::OFS_B_CTRL: res.read_data = ctrl_b;
                    default: ;
                endcase
            end
            kpia_pkg::OP_KEY: if (keys_held < kpia_pkg::FIFO_DEPTH) begin
                key_fifo[push_slot] = it.key_code;
                push_slot++;
                keys_held++;
                res.key_accepted = 1'b1;
            end
            default: ;
        endcase
        mirror_flags();
        res.irq         = ctrl_a[kpia_pkg::FLAG_IRQ];
        res.queued_keys = 5'(keys_held);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_item(kpia_pkg::t_op op, int addr, int wdata, int key);
        t_stim s;
        bit    hit;
        s.hold            = hold_next;
        s.item.operation  = op;
        s.item.address    = 16'(addr);
        s.item.write_data = 8'(wdata);
        s.item.key_code   = 8'(key);
        pending_items.push_back(s);
        hold_next = 1'b0;
        // transactions the adapter ignores don't count toward the total
        hit = (addr >= kpia_pkg::BASE_ADDRESS)
           && (addr < kpia_pkg::BASE_ADDRESS + kpia_pkg::WINDOW_SPAN);
        if (op == kpia_pkg::OP_KEY
            || ((op == kpia_pkg::OP_READ || op == kpia_pkg::OP_WRITE) && hit))
            useful_count++;
    endfunction

    function automatic int reg_addr(int ofs);
        return kpia_pkg::BASE_ADDRESS + ofs;
    endfunction

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // driver: feeds pending transactions, predicts each one as it is taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_stim s;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
            clear_adapter();
        end else begin
            if (in_valid && !o_in_stall) begin
                expected_results.push_back(adapter_result(in_item));
                sent_count++;
            end
            // a stalled transaction stays on the bus unchanged
            if (!(in_valid && o_in_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() != 0 &&
                             (!pending_items[0].hold || expected_results.size() == 0)) begin
                    s = pending_items.pop_front();
                    in_item  <= s.item;
                    in_valid <= 1'b1;
                    // calm stretch of 50 transactions out of every 200
                    gap_left = pick_gap((sent_count % 200) < 50);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random result stalls and field-by-field comparison
    // ------------------------------------------------------------------------
    task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch on result %0d, %s: expected %0h, got %0h",
                         sent_count - expected_results.size(), fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        kpia_pkg::t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            cycle_count++;
            if (o_out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h with nothing outstanding", o_out_item);
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.read_data, o_out_item.read_data);
                    check_field("key_accepted", 8'(want.key_accepted),
                                8'(o_out_item.key_accepted));
                    check_field("irq", 8'(want.irq), 8'(o_out_item.irq));
                    check_field("queued_keys", 8'(want.queued_keys),
                                8'(o_out_item.queued_keys));
                end
            end
            // stall runs, with calm stretches in which no new run starts
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if ((cycle_count % 1000) >= 250 && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap(1'b0);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when neither channel moves for too long
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int kind;
        int n;
        int ofs;
        int next_hold;

        // directed: reset values, empty reads, flag mirroring, every register
        queue_item(kpia_pkg::OP_READ,  reg_addr(kpia_pkg::OFS_A_CTRL), 0, 0);
        // empty fifo reads zero
        queue_item(kpia_pkg::OP_READ,  reg_addr(kpia_pkg::OFS_A_DATA), 0, 0);
        // write to the flag bits, read back with live flags
        queue_item(kpia_pkg::OP_WRITE, reg_addr(kpia_pkg::OFS_A_CTRL), 8'hff, 0);
        queue_item(kpia_pkg::OP_READ,  reg_addr(kpia_pkg::OFS_A_CTRL), 0, 0);
        queue_item(kpia_pkg::OP_KEY,   0, 0, 8'h00);
        queue_item(kpia_pkg::OP_KEY,   0, 0, 8'hff);
        // available and irq set
        queue_item(kpia_pkg::OP_READ,  reg_addr(kpia_pkg::OFS_A_CTRL), 0, 0);
        queue_item(kpia_pkg::OP_READ,  reg_addr(kpia_pkg::OFS_A_DATA), 0, 0);
        queue_item(kpia_pkg::OP_READ,  reg_addr(kpia_pkg::OFS_A_DATA), 0, 0);
        queue_item(kpia_pkg::OP_READ,  reg_addr(kpia_pkg::OFS_A_DATA), 0, 0);
        // port A data write ignored
        queue_item(kpia_pkg::OP_WRITE, reg_addr(kpia_pkg::OFS_A_DATA), 8'haa, 0);
        queue_item(kpia_pkg::OP_WRITE, reg_addr(kpia_pkg::OFS_A_DIR),  8'hff, 0);
        queue_item(kpia_pkg::OP_READ,  reg_addr(kpia_pkg::OFS_A_DIR),  0, 0);
        queue_item(kpia_pkg::OP_WRITE, reg_addr(kpia_pkg::OFS_B_DATA), 8'ha5, 0);
        queue_item(kpia_pkg::OP_READ,  reg_addr(kpia_pkg::OFS_B_DATA), 0, 0);
        queue_item(kpia_pkg::OP_WRITE, reg_addr(kpia_pkg::OFS_B_DIR),  8'hff, 0);
        queue_item(kpia_pkg::OP_READ,  reg_addr(kpia_pkg::OFS_B_DIR),  0, 0);
        queue_item(kpia_pkg::OP_WRITE, reg_addr(kpia_pkg::OFS_B_CTRL), 8'h5a, 0);
        queue_item(kpia_pkg::OP_READ,  reg_addr(kpia_pkg::OFS_B_CTRL), 0, 0);
        // reserved offsets
        queue_item(kpia_pkg::OP_WRITE, reg_addr(6), 8'hff, 0);
        queue_item(kpia_pkg::OP_READ,  reg_addr(7), 0, 0);
        // just outside the window
        queue_item(kpia_pkg::OP_WRITE, kpia_pkg::BASE_ADDRESS - 1, 8'hff, 0);
        queue_item(kpia_pkg::OP_READ,  kpia_pkg::BASE_ADDRESS + kpia_pkg::WINDOW_SPAN, 0, 0);
        queue_item(kpia_pkg::OP_READ,  16'hffff, 8'hff, 8'hff);
        // unused operation code
        queue_item(kpia_pkg::OP_NONE,  16'hffff, 8'hff, 8'hff);

        // random: mostly well-formed key, pop and register sequences, plus noise
        hold_next = 1'b1;
        next_hold = useful_count + 300;
        while (useful_count < USEFUL_ITEMS) begin
            if (useful_count >= next_hold) begin
                hold_next = 1'b1;
                next_hold += 300;
            end
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                n = $urandom_range(1, 6);
                repeat (n) queue_item(kpia_pkg::OP_KEY, $urandom_range(0, 65535),
                                      $urandom_range(0, 255), $urandom_range(0, 255));
            end else if (kind < 45) begin
                n = $urandom_range(1, 6);
                repeat (n) queue_item(kpia_pkg::OP_READ, reg_addr(kpia_pkg::OFS_A_DATA),
                                      $urandom_range(0, 255), $urandom_range(0, 255));
            end else if (kind < 60) begin
                ofs = $urandom_range(0, kpia_pkg::WINDOW_SPAN - 1);
                queue_item(kpia_pkg::OP_WRITE, reg_addr(ofs), $urandom_range(0, 255),
                           $urandom_range(0, 255));
                queue_item(kpia_pkg::OP_READ, reg_addr(ofs), $urandom_range(0, 255),
                           $urandom_range(0, 255));
            end else if (kind < 68) begin
                queue_item(kpia_pkg::OP_READ, reg_addr(kpia_pkg::OFS_A_CTRL),
                           $urandom_range(0, 255), $urandom_range(0, 255));
            end else if (kind < 75) begin
                queue_item(kpia_pkg::OP_WRITE, reg_addr(kpia_pkg::OFS_A_CTRL),
                           $urandom_range(0, 255), $urandom_range(0, 255));
            end else if (kind < 80) begin
                // overfill so the last keys are dropped, then drain it all
                n = $urandom_range(kpia_pkg::FIFO_DEPTH + 1, kpia_pkg::FIFO_DEPTH + 3);
                repeat (n) queue_item(kpia_pkg::OP_KEY, 0, 0, $urandom_range(0, 255));
                queue_item(kpia_pkg::OP_READ, reg_addr(kpia_pkg::OFS_A_CTRL), 0, 0);
                repeat (kpia_pkg::FIFO_DEPTH + 2)
                    queue_item(kpia_pkg::OP_READ, reg_addr(kpia_pkg::OFS_A_DATA), 0, 0);
            end else begin
                // noise: any operation, any address, some right around the window
                if ($urandom_range(0, 1) == 0)
                    ofs = $urandom_range(0, 65535);
                else
                    ofs = $urandom_range(kpia_pkg::BASE_ADDRESS - 2,
                                         kpia_pkg::BASE_ADDRESS + kpia_pkg::WINDOW_SPAN + 1);
                queue_item(kpia_pkg::t_op'($urandom_range(0, 3)), ofs,
                           $urandom_range(0, 255), $urandom_range(0, 255));
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything sent, everything back, then a wait for strays
        while (pending_items.size() != 0 || in_valid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
